// File: rtl/sha_pkg.sv
`default_nettype none
package sha_pkg;

	localparam int WORD_W      = 32;
	localparam int HASH_WORDS  = 8;
	localparam int BLOCK_WORDS = 16;
	localparam int QUEUE_DEPTH = 4;

	// Message schedule word as it travels from the front end to the core
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              fin;
	} sha_word_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] iv_word(input logic [2:0] i);
		case (i)
			3'd0:    iv_word = 32'h6a09e667;
			3'd1:    iv_word = 32'hbb67ae85;
			3'd2:    iv_word = 32'h3c6ef372;
			3'd3:    iv_word = 32'ha54ff53a;
			3'd4:    iv_word = 32'h510e527f;
			3'd5:    iv_word = 32'h9b05688c;
			3'd6:    iv_word = 32'h1f83d9ab;
			default: iv_word = 32'h5be0cd19;
		endcase
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] r);
		case (r)
			6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: rtl/sha_fifo.sv
`default_nettype none
module sha_fifo
	import sha_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  wire sha_word_t wr_data,
	output logic           wr_full,
	input  wire logic      rd_en,
	output sha_word_t      rd_data,
	output logic           rd_empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	sha_word_t       entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign wr_full  = (count_q == CntW'(Depth));
	assign rd_empty = (count_q == '0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign do_wr    = wr_en && !wr_full;
	assign do_rd    = rd_en && !rd_empty;

	// Store incoming requests
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/sha_front.sv
`default_nettype none
module sha_front
	import sha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] msg_word,
	input  wire logic [2:0]  word_bytes,
	input  wire logic        last_word,
	output logic             q_push,
	output sha_word_t        q_data,
	input  wire logic        q_full
);

	typedef enum logic {
		FR_TAKE,
		FR_PAD
	} front_state_t;

	front_state_t state_q;
	logic [3:0]   idx_q;
	logic [63:0]  bitlen_q;
	logic [63:0]  len_q;
	logic         pad_first_q;
	logic         len_ok_q;

	logic         accept;
	logic [2:0]   nb_sat;
	logic [31:0]  keep_mask;
	logic [31:0]  marker;
	logic [31:0]  tail_word;
	logic [63:0]  total_bits;

	assign full   = (state_q != FR_TAKE) || q_full;
	assign accept = push && !full;

	// Trim the last word and place the end marker after its valid bytes
	always_comb begin
		nb_sat = (word_bytes > 3'd4) ? 3'd4 : word_bytes;
		case (nb_sat)
			3'd0: begin
				keep_mask = 32'h0000_0000;
				marker    = 32'h8000_0000;
			end
			3'd1: begin
				keep_mask = 32'hff00_0000;
				marker    = 32'h0080_0000;
			end
			3'd2: begin
				keep_mask = 32'hffff_0000;
				marker    = 32'h0000_8000;
			end
			3'd3: begin
				keep_mask = 32'hffff_ff00;
				marker    = 32'h0000_0080;
			end
			default: begin
				keep_mask = 32'hffff_ffff;
				marker    = 32'h0000_0000;
			end
		endcase
		tail_word  = (msg_word & keep_mask) | marker;
		total_bits = bitlen_q + 64'({idx_q, 5'b0}) + 64'({nb_sat, 3'b0});
	end

	// Drive the schedule queue
	always_comb begin
		q_push = 1'b0;
		q_data = '0;
		case (state_q)
			FR_TAKE: begin
				q_push      = accept;
				q_data.word = (last_word && nb_sat != 3'd4) ? tail_word : msg_word;
			end
			FR_PAD: begin
				q_push = !q_full;
				if (pad_first_q) begin
					q_data.word = 32'h8000_0000;
				end else if (len_ok_q && idx_q == 4'd14) begin
					q_data.word = len_q[63:32];
				end else if (len_ok_q && idx_q == 4'd15) begin
					q_data.word = len_q[31:0];
					q_data.fin  = 1'b1;
				end
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// Track block fill, message length and padding progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FR_TAKE;
			idx_q       <= '0;
			bitlen_q    <= '0;
			len_q       <= '0;
			pad_first_q <= 1'b0;
			len_ok_q    <= 1'b0;
		end else begin
			case (state_q)
				FR_TAKE: begin
					if (accept) begin
						idx_q <= idx_q + 1'b1;
						if (!last_word) begin
							if (idx_q == 4'd15) begin
								bitlen_q <= bitlen_q + 64'd512;
							end
						end else begin
							len_q       <= total_bits;
							bitlen_q    <= '0;
							pad_first_q <= (nb_sat == 3'd4);
							// A tail word that closes the block leaves a fresh block for the length
							if (nb_sat == 3'd4) begin
								len_ok_q <= (idx_q <= 4'd12) || (idx_q == 4'd15);
							end else begin
								len_ok_q <= (idx_q <= 4'd13) || (idx_q == 4'd15);
							end
							state_q <= FR_PAD;
						end
					end
				end
				FR_PAD: begin
					if (!q_full) begin
						idx_q       <= idx_q + 1'b1;
						pad_first_q <= 1'b0;
						if (idx_q == 4'd15) begin
							if (len_ok_q && !pad_first_q) begin
								state_q <= FR_TAKE;
							end else begin
								len_ok_q <= 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= FR_TAKE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/sha_core.sv
`default_nettype none
module sha_core
	import sha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  wire sha_word_t   q_data,
	output logic             q_pop,
	input  wire logic        pop,
	output logic             empty,
	output logic [31:0]      digest_word,
	output logic [2:0]       digest_index,
	output logic             last_digest
);

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ROUND,
		BK_UPDATE
	} core_state_t;

	core_state_t state_q;
	logic [5:0]  rnd_q;
	logic        fin_q;
	logic [31:0] hash_q [HASH_WORDS];
	logic [31:0] dig_q  [HASH_WORDS];
	logic        dig_valid_q;
	logic [2:0]  dig_idx_q;

	logic [31:0] work_q [HASH_WORDS];
	logic [31:0] w_q    [BLOCK_WORDS];
	logic [31:0] wn_q;

	logic        early;
	logic        step;
	logic        load;
	logic [31:0] w_in;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] w_next;

	assign early = (rnd_q < 6'd16);
	assign step  = (state_q == BK_ROUND) && (!early || !q_empty);
	assign q_pop = (state_q == BK_ROUND) && early && !q_empty;
	assign load  = (state_q == BK_IDLE) && !q_empty;

	// One compression round and the schedule word for the round after
	always_comb begin
		w_in   = early ? q_data.word : wn_q;
		ch     = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
		maj    = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
		t1     = work_q[7] + big_sigma1(work_q[4]) + ch + round_k(rnd_q) + w_in;
		t2     = big_sigma0(work_q[0]) + maj;
		w_next = small_sigma1(w_q[15]) + w_q[10] + small_sigma0(w_q[2]) + w_q[1];
	end

	assign empty        = !dig_valid_q;
	assign digest_word  = dig_q[0];
	assign digest_index = dig_idx_q;
	assign last_digest  = (dig_idx_q == 3'd7);

	// Round registers and schedule window
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				work_q[i] <= hash_q[i];
			end
		end else if (step) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BLOCK_WORDS - 1] <= w_in;
			wn_q                 <= w_next;
		end
	end

	// Sequence the block, fold into the hash and hold the digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			rnd_q       <= '0;
			fin_q       <= 1'b0;
			dig_valid_q <= 1'b0;
			dig_idx_q   <= '0;
			for (int i = 0; i < HASH_WORDS; i++) begin
				hash_q[i] <= iv_word(3'(i));
				dig_q[i]  <= '0;
			end
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (load) begin
						rnd_q   <= '0;
						state_q <= BK_ROUND;
					end
				end
				BK_ROUND: begin
					if (step) begin
						rnd_q <= rnd_q + 1'b1;
						if (rnd_q == 6'd15) begin
							fin_q <= q_data.fin;
						end
						if (rnd_q == 6'd63) begin
							state_q <= BK_UPDATE;
						end
					end
				end
				BK_UPDATE: begin
					if (!fin_q) begin
						for (int i = 0; i < HASH_WORDS; i++) begin
							hash_q[i] <= hash_q[i] + work_q[i];
						end
						state_q <= BK_IDLE;
					end else if (!dig_valid_q) begin
						for (int i = 0; i < HASH_WORDS; i++) begin
							dig_q[i]  <= hash_q[i] + work_q[i];
							hash_q[i] <= iv_word(3'(i));
						end
						dig_valid_q <= 1'b1;
						dig_idx_q   <= '0;
						state_q     <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase

			// Drop the head digest word on each request taken
			if (pop && dig_valid_q) begin
				for (int i = 0; i < HASH_WORDS - 1; i++) begin
					dig_q[i] <= dig_q[i + 1];
				end
				dig_idx_q <= dig_idx_q + 1'b1;
				if (dig_idx_q == 3'd7) begin
					dig_valid_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/sha256_stream_hash.sv
`default_nettype none
// SHA-256 engine for a byte message streamed as big-endian 32-bit words.
// Push one word per request; raise last_word on the final word, with
// word_bytes (0 to 4) giving its valid leading bytes, and the block pads
// the message, appends the bit length and returns the eight digest words
// in order (digest_index 0 to 7, last_digest on the eighth); the hash
// state starts afresh for the next message when the digest is captured.
// The front end takes one word per cycle into a short schedule queue
// while the queue has room and no padding is being written; the core
// runs one round per cycle unless it waits on an empty queue for message
// words, and works each 64-byte block as load, 64 rounds, fold. A message
// ending within eight bytes of a block boundary costs one extra padding
// block. One finished digest is held while the next one is compressed.
module sha256_stream_hash
	import sha_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] msg_word,
	input  wire logic [2:0]  word_bytes,
	input  wire logic        last_word,
	input  wire logic        pop,
	output logic             empty,
	output logic [31:0]      digest_word,
	output logic [2:0]       digest_index,
	output logic             last_digest
);

	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	sha_word_t q_wr_data;
	sha_word_t q_rd_data;

	sha_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.msg_word   (msg_word),
		.word_bytes (word_bytes),
		.last_word  (last_word),
		.q_push     (q_push),
		.q_data     (q_wr_data),
		.q_full     (q_full)
	);

	sha_fifo #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_data  (q_wr_data),
		.wr_full  (q_full),
		.rd_en    (q_pop),
		.rd_data  (q_rd_data),
		.rd_empty (q_empty)
	);

	sha_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_rd_data),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.digest_word  (digest_word),
		.digest_index (digest_index),
		.last_digest  (last_digest)
	);

endmodule
`default_nettype wire
